// ===== rtl/wsd_pkg.sv =====
package wsd_pkg;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT16   = 3'd2,
    PH_EXT64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_e;

  localparam logic [6:0] LEN16_CODE = 7'd126;
  localparam logic [6:0] LEN64_CODE = 7'd127;

  // value of the byte counter on the last byte of each multi-byte field
  localparam logic [2:0] EXT16_LAST = 3'd1;
  localparam logic [2:0] EXT64_LAST = 3'd7;
  localparam logic [2:0] KEY_LAST   = 3'd3;

  localparam logic RESULT_HEADER  = 1'b0;
  localparam logic RESULT_PAYLOAD = 1'b1;

  typedef struct packed {
    logic        kind;
    logic        fin;
    logic [3:0]  opcode;
    logic        masked;
    logic [62:0] decoded_len;
    logic [3:0]  header_length;
    logic [7:0]  payload_byte;
    logic        last;
    logic        length_error;
  } wsd_result_t;

endpackage

// ===== rtl/websocket_frame_deframer.sv =====
// Output: a byte that completes a header or carries payload yields a registered
//   result, kept in the skid entry on a stall; other header bytes yield nothing.
// Throughput: one byte per cycle while in_stall_o is low; the output register
//   plus skid entry take one more result while a result waits, then stall input.
// Reset: rst_ni is asynchronous, active low; it clears the parse phase,
//   counters and output valid, so the next byte is a first header byte.
module websocket_frame_deframer (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        message_start_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic        fin_flag_o,
  output logic [3:0]  frame_opcode_o,
  output logic        masked_flag_o,
  output logic [62:0] decoded_len_o,
  output logic [3:0]  header_length_o,
  output logic [7:0]  payload_byte_o,
  output logic        last_of_frame_o,
  output logic        length_error_o
);

  logic                 accept;
  logic                 res_valid;
  logic                 skid_full;
  wsd_pkg::wsd_result_t res;
  wsd_pkg::wsd_result_t out_data;

  // Stall only when the skid entry is occupied; that is a registered signal,
  // so the input side never waits on the output stall combinationally.
  assign in_stall_o = skid_full;
  assign accept     = in_valid_i && !skid_full;

  // Header parse, key capture and payload unmasking, one byte per transfer.
  wsd_parser u_parser (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .message_start_i (message_start_i),
    .res_valid_o     (res_valid),
    .res_o           (res)
  );

  // Result register with one skid entry: a result can be produced on the
  // same edge that the downstream side first stalls without being dropped.
  wsd_out_skid u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept && res_valid),
    .push_data_i (res),
    .full_o      (skid_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  // Unpack the result onto the field ports.
  assign result_kind_o    = out_data.kind;
  assign fin_flag_o       = out_data.fin;
  assign frame_opcode_o   = out_data.opcode;
  assign masked_flag_o    = out_data.masked;
  assign decoded_len_o    = out_data.decoded_len;
  assign header_length_o  = out_data.header_length;
  assign payload_byte_o   = out_data.payload_byte;
  assign last_of_frame_o  = out_data.last;
  assign length_error_o   = out_data.length_error;

endmodule

// ===== rtl/wsd_parser.sv =====
module wsd_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 accept_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 message_start_i,
  output logic                 res_valid_o,
  output wsd_pkg::wsd_result_t res_o
);

  wsd_pkg::phase_e phase_q, phase_d, ph;

  logic [2:0]  ext_cnt_q, ext_cnt_d;
  logic        fin_q, fin_d;
  logic [3:0]  opcode_q, opcode_d;
  logic        masked_q, masked_d;
  logic [63:0] accum_q, accum_d;
  logic [62:0] remain_q, remain_d;
  logic [31:0] key_q, key_d;
  logic [1:0]  key_idx_q, key_idx_d;
  logic [3:0]  hdr_cnt_q, hdr_cnt_d;

  logic        emit_hdr;
  logic        emit_pay;
  logic        len_err;
  logic [63:0] acc_shift;
  logic [3:0]  hdr_cnt_inc;
  logic [62:0] remain_dec;
  logic [7:0]  key_byte;

  assign ph          = message_start_i ? wsd_pkg::PH_HDR0 : phase_q;
  assign acc_shift   = {accum_q[55:0], data_byte_i};
  assign hdr_cnt_inc = hdr_cnt_q + 4'd1;
  assign remain_dec  = remain_q - 63'd1;

  always_comb begin
    unique case (key_idx_q)
      2'd0:    key_byte = key_q[31:24];
      2'd1:    key_byte = key_q[23:16];
      2'd2:    key_byte = key_q[15:8];
      default: key_byte = key_q[7:0];
    endcase
  end

  // datapath and result
  always_comb begin
    ext_cnt_d = ext_cnt_q;
    fin_d     = fin_q;
    opcode_d  = opcode_q;
    masked_d  = masked_q;
    accum_d   = accum_q;
    remain_d  = remain_q;
    key_d     = key_q;
    key_idx_d = key_idx_q;
    hdr_cnt_d = hdr_cnt_q;
    emit_hdr  = 1'b0;
    emit_pay  = 1'b0;
    len_err   = 1'b0;

    unique case (ph)
      wsd_pkg::PH_HDR1: begin
        masked_d  = data_byte_i[7];
        hdr_cnt_d = 4'd2;
        ext_cnt_d = 3'd0;
        accum_d   = 64'd0;
        if (data_byte_i[6:0] != wsd_pkg::LEN16_CODE &&
            data_byte_i[6:0] != wsd_pkg::LEN64_CODE) begin
          accum_d = {57'd0, data_byte_i[6:0]};
          if (data_byte_i[7]) begin
            key_d = 32'd0;
          end else begin
            emit_hdr = 1'b1;
          end
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        accum_d   = acc_shift;
        hdr_cnt_d = hdr_cnt_inc;
        ext_cnt_d = ext_cnt_q + 3'd1;
        if (ext_cnt_q == ((ph == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_LAST
                                                    : wsd_pkg::EXT64_LAST)) begin
          ext_cnt_d = 3'd0;
          if (masked_q) begin
            // keep the top bit as the error mark until the key is in
            key_d = 32'd0;
          end else begin
            len_err  = acc_shift[63];
            accum_d  = {1'b0, acc_shift[62:0]};
            emit_hdr = 1'b1;
          end
        end
      end
      wsd_pkg::PH_KEY: begin
        key_d     = {key_q[23:0], data_byte_i};
        hdr_cnt_d = hdr_cnt_inc;
        ext_cnt_d = ext_cnt_q + 3'd1;
        if (ext_cnt_q == wsd_pkg::KEY_LAST) begin
          ext_cnt_d = 3'd0;
          len_err   = accum_q[63];
          accum_d   = {1'b0, accum_q[62:0]};
          emit_hdr  = 1'b1;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        emit_pay  = 1'b1;
        remain_d  = remain_dec;
        key_idx_d = key_idx_q + 2'd1;
      end
      default: begin
        fin_d     = data_byte_i[7];
        opcode_d  = data_byte_i[3:0];
        masked_d  = 1'b0;
        accum_d   = 64'd0;
        remain_d  = 63'd0;
        key_d     = 32'd0;
        key_idx_d = 2'd0;
        ext_cnt_d = 3'd0;
        hdr_cnt_d = 4'd1;
      end
    endcase

    if (emit_hdr) begin
      remain_d  = accum_d[62:0];
      key_idx_d = 2'd0;
    end

    res_valid_o = emit_hdr | emit_pay;
    res_o       = '0;
    res_o.fin   = fin_q;
    res_o.opcode = opcode_q;
    res_o.masked = masked_d;
    if (emit_pay) begin
      res_o.kind         = wsd_pkg::RESULT_PAYLOAD;
      res_o.payload_byte = data_byte_i ^ (masked_q ? key_byte : 8'd0);
      res_o.last         = (remain_dec == 63'd0);
    end else begin
      res_o.kind           = wsd_pkg::RESULT_HEADER;
      res_o.decoded_len    = accum_d[62:0];
      res_o.header_length  = hdr_cnt_d;
      res_o.last           = (accum_d == 64'd0);
      res_o.length_error   = len_err;
    end
  end

  // next phase
  always_comb begin
    phase_d = phase_q;
    unique case (ph)
      wsd_pkg::PH_HDR1: begin
        if (data_byte_i[6:0] == wsd_pkg::LEN16_CODE) begin
          phase_d = wsd_pkg::PH_EXT16;
        end else if (data_byte_i[6:0] == wsd_pkg::LEN64_CODE) begin
          phase_d = wsd_pkg::PH_EXT64;
        end else if (data_byte_i[7]) begin
          phase_d = wsd_pkg::PH_KEY;
        end else begin
          phase_d = (accum_d == 64'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
        end
      end
      wsd_pkg::PH_EXT16, wsd_pkg::PH_EXT64: begin
        if (ext_cnt_q == ((ph == wsd_pkg::PH_EXT16) ? wsd_pkg::EXT16_LAST
                                                    : wsd_pkg::EXT64_LAST)) begin
          if (masked_q) begin
            phase_d = wsd_pkg::PH_KEY;
          end else begin
            phase_d = (accum_d == 64'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
          end
        end else begin
          phase_d = ph;
        end
      end
      wsd_pkg::PH_KEY: begin
        if (ext_cnt_q == wsd_pkg::KEY_LAST) begin
          phase_d = (accum_d == 64'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
        end else begin
          phase_d = wsd_pkg::PH_KEY;
        end
      end
      wsd_pkg::PH_PAYLOAD: begin
        phase_d = (remain_dec == 63'd0) ? wsd_pkg::PH_HDR0 : wsd_pkg::PH_PAYLOAD;
      end
      default: begin
        phase_d = wsd_pkg::PH_HDR1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= wsd_pkg::PH_HDR0;
      ext_cnt_q <= 3'd0;
      key_idx_q <= 2'd0;
      hdr_cnt_q <= 4'd0;
      fin_q     <= 1'b0;
      opcode_q  <= 4'd0;
      masked_q  <= 1'b0;
    end else if (accept_i) begin
      phase_q   <= phase_d;
      ext_cnt_q <= ext_cnt_d;
      key_idx_q <= key_idx_d;
      hdr_cnt_q <= hdr_cnt_d;
      fin_q     <= fin_d;
      opcode_q  <= opcode_d;
      masked_q  <= masked_d;
    end
  end

  // wide fields are always written in the first header byte before use
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      accum_q  <= accum_d;
      remain_q <= remain_d;
      key_q    <= key_d;
    end
  end

endmodule

// ===== rtl/wsd_out_skid.sv =====
module wsd_out_skid (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wsd_pkg::wsd_result_t push_data_i,
  output logic                 full_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output wsd_pkg::wsd_result_t out_data_o
);

  logic                 out_valid_q, out_valid_d;
  logic                 skid_valid_q, skid_valid_d;
  wsd_pkg::wsd_result_t out_data_q, out_data_d;
  wsd_pkg::wsd_result_t skid_data_q, skid_data_d;
  logic                 load_out;

  assign load_out = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_data_d   = out_data_q;
    skid_valid_d = skid_valid_q;
    skid_data_d  = skid_data_q;
    if (load_out) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_data_d   = skid_data_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_data_d  = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_data_d  = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/wsd_checker.sv =====
module wsd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic [62:0] decoded_len_o,
  input logic [3:0]  header_length_o,
  input logic [7:0]  payload_byte_o,
  input logic        last_of_frame_o,
  input logic        length_error_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(payload_byte_o) &&
      $stable(decoded_len_o) && $stable(result_kind_o) && $stable(last_of_frame_o))
    else $error("stalled result changed");

  // input stalls only behind a waiting result
  a_stall_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |=> !in_stall_o)
    else $error("input stalled with empty output");

  // header results carry a sane header size; an error needs the long form
  a_hdr_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_kind_o |->
      header_length_o >= 4'd2 && header_length_o <= 4'd14 && payload_byte_o == 8'd0 &&
      (!length_error_o || header_length_o >= 4'd10))
    else $error("bad header result");

  // payload results leave header-only fields clear
  a_pay_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o |->
      decoded_len_o == 63'd0 && header_length_o == 4'd0 && !length_error_o)
    else $error("bad payload result");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (.*);
